FILE: design/space_vector_pwm_duty_defines.svh
// Assertion macros shared by the space vector PWM duty block.
`ifndef SPACE_VECTOR_PWM_DUTY_DEFINES_SVH
`define SPACE_VECTOR_PWM_DUTY_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define SVPD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define SVPD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/svpd_pkg.sv
// Types and constants of the space vector PWM duty block.
package svpd_pkg;

   localparam int unsigned DIV_STEPS = 18;

   localparam logic [17:0] Q_LIMIT      = 18'd131072;
   localparam logic [15:0] K_INV_SQRT3  = 16'd37837;
   localparam logic [16:0] K_TWO_SQRT3  = 17'd75674;
   localparam logic [15:0] PERIOD_RESET = 16'd1000;

   typedef enum logic [2:0] {
      SEC1 = 3'd0,
      SEC2 = 3'd1,
      SEC3 = 3'd2,
      SEC4 = 3'd3,
      SEC5 = 3'd4,
      SEC6 = 3'd5
   } sector_type;

   typedef struct packed {
      logic signed [15:0] v_alpha;
      logic signed [15:0] v_beta;
      logic [15:0]        bus_voltage;
   } req_type;

   typedef struct packed {
      logic [15:0] duty_u;
      logic [15:0] duty_v;
      logic [15:0] duty_w;
      logic [2:0]  sector_index;
      logic        bus_fault;
   } rsp_type;

   // Per-item control that rides alongside the divider stages.
   typedef struct packed {
      logic        sign_a;
      logic        sign_b;
      logic        ovf_a;
      logic        ovf_b;
      logic        fault;
      logic [15:0] period;
   } side_type;

endpackage

FILE: design/svpd_div.sv
// Pipelined restoring divider: 18 quotient bits of (mag << 16) / den, one bit per stage.
module svpd_div (
   input  logic        clock,
   input  logic [15:0] mag,
   input  logic [15:0] den,
   output logic [17:0] quo
);
   import svpd_pkg::*;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [16:0] rem_ff;
      logic [17:0] quo_ff;
      logic [15:0] den_ff;
      logic [1:0]  low_ff;
      logic [16:0] rem_prev;
      logic [17:0] quo_prev;
      logic [15:0] den_prev;
      logic [1:0]  low_prev;
      logic [16:0] trial;
      logic [16:0] rem_in;
      logic        ge;

      if (k == 0) begin : g_first
         // upper dividend bits are known to sit below den (overflow caught outside)
         assign rem_prev = {3'b000, mag[15:2]};
         assign quo_prev = '0;
         assign den_prev = den;
         assign low_prev = mag[1:0];
      end else begin : g_next
         assign rem_prev = g_step[k-1].rem_ff;
         assign quo_prev = g_step[k-1].quo_ff;
         assign den_prev = g_step[k-1].den_ff;
         assign low_prev = g_step[k-1].low_ff;
      end

      assign trial  = {rem_prev[15:0], low_prev[1]};
      assign ge     = trial >= {1'b0, den_prev};
      assign rem_in = ge ? (trial - {1'b0, den_prev}) : trial;

      always_ff @(posedge clock) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_prev[16:0], ge};
         den_ff <= den_prev;
         low_ff <= {low_prev[0], 1'b0};
      end
   end

   assign quo = g_step[DIV_STEPS-1].quo_ff;

endmodule

FILE: design/space_vector_pwm_duty.sv
// Top level of the six-sector space vector PWM duty generator.
// Usage:
//   Input: drive req_item (v_alpha, v_beta, bus_voltage) and pulse start. busy is
//   always low, so an item is taken at every edge with start high, one per cycle.
//   Result: rsp_valid is high for one cycle with rsp_item (three duties, sector,
//   bus fault). There is no back pressure; the receiver must take it then.
//   Pipeline: the result passes through the entry stage, the 18-stage
//   bit-per-stage divider that normalizes by the bus voltage, and the
//   coefficient multiply, sector select, period multiply, sum and clamp
//   stages. Throughput is one item per cycle.
//   Config: csr_data is written into the period register when csr_valid is high;
//   csr_ready is always high. Each item samples the period at entry.
//   Zero bus voltage gives bus_fault with period/2 on every phase and sector 0.
//   Reset: synchronous, clears the pipeline valid bits and sets period to 1000.
`include "space_vector_pwm_duty_defines.svh"

module space_vector_pwm_duty (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  svpd_pkg::req_type req_item,
   output logic             rsp_valid,
   output svpd_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   import svpd_pkg::*;

   // config
   logic [15:0] period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         period_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // entry stage
   logic        ent_vld_ff;
   logic [15:0] ent_mag_a_ff, ent_mag_b_ff, ent_bus_ff;
   side_type    ent_side_ff;
   logic [15:0] mag_a_in, mag_b_in;
   side_type    side_in;

   always_comb begin
      mag_a_in = req_item.v_alpha[15] ? (16'd0 - req_item.v_alpha) : req_item.v_alpha;
      mag_b_in = req_item.v_beta[15]  ? (16'd0 - req_item.v_beta)  : req_item.v_beta;
      side_in.sign_a = req_item.v_alpha[15];
      side_in.sign_b = req_item.v_beta[15];
      // quotient reaches 4.0 or more: saturate
      side_in.ovf_a  = {2'b00, mag_a_in} >= {req_item.bus_voltage, 2'b00};
      side_in.ovf_b  = {2'b00, mag_b_in} >= {req_item.bus_voltage, 2'b00};
      side_in.fault  = req_item.bus_voltage == 16'd0;
      side_in.period = period_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= 1'b0;
      end else begin
         ent_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      ent_mag_a_ff <= mag_a_in;
      ent_mag_b_ff <= mag_b_in;
      ent_bus_ff   <= req_item.bus_voltage;
      ent_side_ff  <= side_in;
   end

   // divider stages
   logic [17:0] quo_a, quo_b;

   svpd_div u_div_a (.clock(clock), .mag(ent_mag_a_ff), .den(ent_bus_ff), .quo(quo_a));
   svpd_div u_div_b (.clock(clock), .mag(ent_mag_b_ff), .den(ent_bus_ff), .quo(quo_b));

   logic     dl_vld_ff  [DIV_STEPS];
   side_type dl_side_ff [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STEPS; i++) dl_vld_ff[i] <= 1'b0;
      end else begin
         dl_vld_ff[0] <= ent_vld_ff;
         for (int i = 1; i < DIV_STEPS; i++) dl_vld_ff[i] <= dl_vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      dl_side_ff[0] <= ent_side_ff;
      for (int i = 1; i < DIV_STEPS; i++) dl_side_ff[i] <= dl_side_ff[i-1];
   end

   // coefficient stage: saturate, sign, multiply beta by 1/sqrt3 and 2/sqrt3
   side_type           div_side;
   logic [17:0]        sat_a, sat_b;
   logic [33:0]        kb_prod;
   logic [34:0]        k2b_prod;
   logic signed [19:0] a_in, b_in, kb_in, k2b_in;

   assign div_side = dl_side_ff[DIV_STEPS-1];

   always_comb begin
      sat_a  = (div_side.ovf_a || quo_a > Q_LIMIT) ? Q_LIMIT : quo_a;
      sat_b  = (div_side.ovf_b || quo_b > Q_LIMIT) ? Q_LIMIT : quo_b;
      a_in   = div_side.sign_a ? -$signed({2'b00, sat_a}) : $signed({2'b00, sat_a});
      b_in   = div_side.sign_b ? -$signed({2'b00, sat_b}) : $signed({2'b00, sat_b});
      // truncate toward zero on the magnitude
      kb_prod  = sat_b * K_INV_SQRT3;
      k2b_prod = sat_b * K_TWO_SQRT3;
      kb_in  = div_side.sign_b ? -$signed({2'b00, kb_prod[33:16]})
                               :  $signed({2'b00, kb_prod[33:16]});
      k2b_in = div_side.sign_b ? -$signed({1'b0, k2b_prod[34:16]})
                               :  $signed({1'b0, k2b_prod[34:16]});
   end

   logic               k_vld_ff;
   logic signed [19:0] k_a_ff, k_b_ff, k_kb_ff, k_k2b_ff;
   side_type           k_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_vld_ff <= 1'b0;
      end else begin
         k_vld_ff <= dl_vld_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      k_a_ff    <= a_in;
      k_b_ff    <= b_in;
      k_kb_ff   <= kb_in;
      k_k2b_ff  <= k2b_in;
      k_side_ff <= div_side;
   end

   // sector stage
   sector_type         sec_in;
   logic signed [19:0] x1_in, x2_in;

   always_comb begin
      if (!k_b_ff[19]) begin
         if (!k_a_ff[19]) sec_in = (k_kb_ff > k_a_ff) ? SEC2 : SEC1;
         else             sec_in = (-k_kb_ff > k_a_ff) ? SEC3 : SEC2;
      end else begin
         if (!k_a_ff[19]) sec_in = (-k_kb_ff > k_a_ff) ? SEC5 : SEC6;
         else             sec_in = (k_kb_ff > k_a_ff) ? SEC4 : SEC5;
      end
      unique case (sec_in)
         SEC1: begin x1_in = k_a_ff - k_kb_ff;   x2_in = k_k2b_ff;          end
         SEC2: begin x1_in = k_a_ff + k_kb_ff;   x2_in = k_kb_ff - k_a_ff;  end
         SEC3: begin x1_in = k_k2b_ff;           x2_in = -k_a_ff - k_kb_ff; end
         SEC4: begin x1_in = k_kb_ff - k_a_ff;   x2_in = -k_k2b_ff;         end
         SEC5: begin x1_in = -k_a_ff - k_kb_ff;  x2_in = k_a_ff - k_kb_ff;  end
         default: begin x1_in = -k_k2b_ff;       x2_in = k_a_ff + k_kb_ff;  end
      endcase
   end

   logic               x_vld_ff;
   sector_type         x_sec_ff;
   logic signed [19:0] x_x1_ff, x_x2_ff;
   side_type           x_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff <= 1'b0;
      end else begin
         x_vld_ff <= k_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_sec_ff  <= sec_in;
      x_x1_ff   <= x1_in;
      x_x2_ff   <= x2_in;
      x_side_ff <= k_side_ff;
   end

   // period multiply stage, sign-magnitude
   logic [19:0] x1_mag, x2_mag;

   assign x1_mag = x_x1_ff[19] ? 20'(-x_x1_ff) : 20'(x_x1_ff);
   assign x2_mag = x_x2_ff[19] ? 20'(-x_x2_ff) : 20'(x_x2_ff);

   logic        m_vld_ff;
   logic [34:0] m_p1_ff, m_p2_ff;
   logic        m_s1_ff, m_s2_ff;
   sector_type  m_sec_ff;
   side_type    m_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= x_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      m_p1_ff   <= x1_mag[18:0] * x_side_ff.period;
      m_p2_ff   <= x2_mag[18:0] * x_side_ff.period;
      m_s1_ff   <= x_x1_ff[19];
      m_s2_ff   <= x_x2_ff[19];
      m_sec_ff  <= x_sec_ff;
      m_side_ff <= x_side_ff;
   end

   // sum and phase derivation stage
   logic signed [23:0] t1, t2, ta, tb, sum, h, mid, low;
   logic signed [23:0] du_in, dv_in, dw_in;

   always_comb begin
      t1  = m_s1_ff ? -$signed({5'b0, m_p1_ff[34:16]}) : $signed({5'b0, m_p1_ff[34:16]});
      t2  = m_s2_ff ? -$signed({5'b0, m_p2_ff[34:16]}) : $signed({5'b0, m_p2_ff[34:16]});
      sum = $signed({8'b0, m_side_ff.period}) + t1 + t2;
      h   = sum >>> 1;
      // odd sectors peel t1 first, even sectors t2
      unique case (m_sec_ff)
         SEC1, SEC3, SEC5: begin ta = t1; tb = t2; end
         default:          begin ta = t2; tb = t1; end
      endcase
      mid = h - ta;
      low = mid - tb;
      unique case (m_sec_ff)
         SEC1: begin du_in = h;   dv_in = mid; dw_in = low; end
         SEC2: begin dv_in = h;   du_in = mid; dw_in = low; end
         SEC3: begin dv_in = h;   dw_in = mid; du_in = low; end
         SEC4: begin dw_in = h;   dv_in = mid; du_in = low; end
         SEC5: begin dw_in = h;   du_in = mid; dv_in = low; end
         default: begin du_in = h; dw_in = mid; dv_in = low; end
      endcase
   end

   logic               t_vld_ff;
   logic signed [23:0] t_du_ff, t_dv_ff, t_dw_ff;
   sector_type         t_sec_ff;
   side_type           t_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else begin
         t_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_du_ff   <= du_in;
      t_dv_ff   <= dv_in;
      t_dw_ff   <= dw_in;
      t_sec_ff  <= m_sec_ff;
      t_side_ff <= m_side_ff;
   end

   // clamp and output stage
   function automatic logic [15:0] clamp_duty(logic signed [23:0] d, logic [15:0] p);
      logic [15:0] r;
      if (d < 0)                       r = 16'd0;
      else if (d > $signed({8'b0, p})) r = p;
      else                             r = d[15:0];
      return r;
   endfunction

   rsp_type     rsp_in;
   rsp_type     rsp_item_ff;
   logic        rsp_valid_ff;
   logic [15:0] out_per_ff;

   always_comb begin
      if (t_side_ff.fault) begin
         rsp_in.duty_u       = t_side_ff.period >> 1;
         rsp_in.duty_v       = t_side_ff.period >> 1;
         rsp_in.duty_w       = t_side_ff.period >> 1;
         rsp_in.sector_index = SEC1;
         rsp_in.bus_fault    = 1'b1;
      end else begin
         rsp_in.duty_u       = clamp_duty(t_du_ff, t_side_ff.period);
         rsp_in.duty_v       = clamp_duty(t_dv_ff, t_side_ff.period);
         rsp_in.duty_w       = clamp_duty(t_dw_ff, t_side_ff.period);
         rsp_in.sector_index = t_sec_ff;
         rsp_in.bus_fault    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= t_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_in;
      out_per_ff  <= t_side_ff.period;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `SVPD_ASSERT_IMP(a_sector_range, rsp_valid, rsp_item.sector_index <= 3'(SEC6), "sector index out of range")
   `SVPD_ASSERT_IMP(a_fault_out, rsp_valid && rsp_item.bus_fault, rsp_item.duty_u == rsp_item.duty_v && rsp_item.duty_v == rsp_item.duty_w && rsp_item.sector_index == 3'(SEC1), "fault result not uniform")
   `SVPD_ASSERT_IMP(a_clamp, rsp_valid, rsp_item.duty_u <= out_per_ff && rsp_item.duty_v <= out_per_ff && rsp_item.duty_w <= out_per_ff, "duty above period")
   `SVPD_ASSERT_NXT(a_csr_write, csr_valid && csr_ready, period_ff == $past(csr_data), "period not written")

endmodule

FILE: dv/svpd_checker.sv
// Checker for the space vector PWM duty block: predicts each item's duties and compares.
module svpd_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  svpd_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  svpd_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [15:0]       csr_data,
   output int                fail_count,
   output int                pending
);
   import svpd_pkg::*;

   logic [15:0] period_shadow;
   rsp_type     duty_queue[$];

   function automatic longint drop_q16(longint p);
      if (p < 0) return -((-p) >>> 16);
      return p >>> 16;
   endfunction

   function automatic longint norm_q16(longint v, longint bus);
      longint q;
      q = (v * 65536) / bus;
      if (q > longint'(Q_LIMIT)) q = longint'(Q_LIMIT);
      if (q < -longint'(Q_LIMIT)) q = -longint'(Q_LIMIT);
      return q;
   endfunction

   function automatic logic [15:0] limit_duty(longint d, longint p);
      if (d < 0) return 16'd0;
      if (d > p) return p[15:0];
      return d[15:0];
   endfunction

   function automatic rsp_type svm_duties(req_type r, logic [15:0] per);
      rsp_type    o;
      longint     p, bus, a, b, kb, k2b, t1, t2, du, dv, dw;
      sector_type sec;
      p   = longint'(per);
      bus = longint'(r.bus_voltage);
      o   = '0;
      if (bus == 0) begin
         o.duty_u    = per >> 1;
         o.duty_v    = per >> 1;
         o.duty_w    = per >> 1;
         o.sector_index = SEC1;
         o.bus_fault = 1'b1;
         return o;
      end
      a   = norm_q16(longint'(r.v_alpha), bus);
      b   = norm_q16(longint'(r.v_beta), bus);
      kb  = drop_q16(longint'(K_INV_SQRT3) * b);
      k2b = drop_q16(longint'(K_TWO_SQRT3) * b);
      if (b >= 0) begin
         if (a >= 0) sec = (kb > a) ? SEC2 : SEC1;
         else        sec = (-kb > a) ? SEC3 : SEC2;
      end else begin
         if (a >= 0) sec = (-kb > a) ? SEC5 : SEC6;
         else        sec = (kb > a) ? SEC4 : SEC5;
      end
      // first duty halved by floor, the other two follow in sector order
      case (sec)
         SEC1: begin
            t1 = drop_q16((a - kb) * p);  t2 = drop_q16(k2b * p);
            du = (p + t1 + t2) >>> 1;  dv = du - t1;  dw = dv - t2;
         end
         SEC2: begin
            t1 = drop_q16((a + kb) * p);  t2 = drop_q16((-a + kb) * p);
            dv = (p + t1 + t2) >>> 1;  du = dv - t2;  dw = du - t1;
         end
         SEC3: begin
            t1 = drop_q16(k2b * p);  t2 = drop_q16((-a - kb) * p);
            dv = (p + t1 + t2) >>> 1;  dw = dv - t1;  du = dw - t2;
         end
         SEC4: begin
            t1 = drop_q16((-a + kb) * p);  t2 = drop_q16(-k2b * p);
            dw = (p + t1 + t2) >>> 1;  dv = dw - t2;  du = dv - t1;
         end
         SEC5: begin
            t1 = drop_q16((-a - kb) * p);  t2 = drop_q16((a - kb) * p);
            dw = (p + t1 + t2) >>> 1;  du = dw - t1;  dv = du - t2;
         end
         default: begin
            t1 = drop_q16(-k2b * p);  t2 = drop_q16((a + kb) * p);
            du = (p + t1 + t2) >>> 1;  dw = du - t2;  dv = dw - t1;
         end
      endcase
      o.duty_u       = limit_duty(du, p);
      o.duty_v       = limit_duty(dv, p);
      o.duty_w       = limit_duty(dw, p);
      o.sector_index = sec;
      o.bus_fault    = 1'b0;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         period_shadow <= PERIOD_RESET;
         duty_queue.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (start && !busy) duty_queue.push_back(svm_duties(req_item, period_shadow));
         if (csr_valid && csr_ready) period_shadow <= csr_data;
         if (rsp_valid) begin
            if (duty_queue.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_item);
               fail_count <= fail_count + 1;
            end else begin
               want = duty_queue.pop_front();
               if (want.duty_u !== rsp_item.duty_u || want.duty_v !== rsp_item.duty_v ||
                   want.duty_w !== rsp_item.duty_w ||
                   want.sector_index !== rsp_item.sector_index ||
                   want.bus_fault !== rsp_item.bus_fault) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_item);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= duty_queue.size();
      end
   end
endmodule

FILE: dv/tb_space_vector_pwm_duty.sv
// Testbench top: drives items and period writes into the duty block and gives the verdict.
module tb_space_vector_pwm_duty;
   import svpd_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;
   int          fail_count;
   int          pending;

   localparam int DRAIN = 40;

   space_vector_pwm_duty u_top (.*);
   svpd_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic send_item(logic signed [15:0] va, logic signed [15:0] vb,
                            logic [15:0] bus, bit allow_gap);
      int gap;
      start    <= 1'b1;
      req_item <= '{v_alpha: va, v_beta: vb, bus_voltage: bus};
      do @(posedge clock); while (busy);
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_items();
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_period(logic [15:0] per);
      drain_items();
      csr_valid <= 1'b1;
      csr_data  <= per;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item(bit allow_gap);
      logic [15:0]        bus;
      logic signed [15:0] va, vb;
      int                 kind;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         // realistic command: magnitude within about the bus voltage
         bus = 16'($urandom_range(1, 65535));
         va  = 16'($signed($urandom_range(0, bus)) - $signed(bus / 2));
         vb  = 16'($signed($urandom_range(0, bus)) - $signed(bus / 2));
      end else if (kind < 9) begin
         bus = (kind == 8) ? 16'($urandom_range(1, 64)) : 16'($urandom);
         va  = 16'($urandom);
         vb  = 16'($urandom);
      end else begin
         bus = 16'd0;
         va  = 16'($urandom);
         vb  = 16'($urandom);
      end
      send_item(va, vb, bus, allow_gap);
   endtask

   task automatic directed_items();
      send_item(16'sd0, 16'sd0, 16'd0, 1'b0);
      send_item(16'sd1000, -16'sd1000, 16'd0, 1'b0);
      send_item(16'sd0, 16'sd0, 16'd1000, 1'b0);
      send_item(16'sd32767, 16'sd32767, 16'd1, 1'b0);
      send_item(-16'sd32768, -16'sd32768, 16'd1, 1'b0);
      send_item(16'sd32767, -16'sd32768, 16'd65535, 1'b0);
      send_item(-16'sd32768, 16'sd32767, 16'd65535, 1'b0);
      // commands for sectors SEC1, SEC2, SEC3, SEC5 (two) and SEC6
      send_item(16'sd1000, 16'sd300, 16'd2000, 1'b0);
      send_item(16'sd300, 16'sd1000, 16'd2000, 1'b0);
      send_item(-16'sd1000, 16'sd300, 16'd2000, 1'b0);
      send_item(-16'sd300, -16'sd1000, 16'd2000, 1'b0);
      send_item(16'sd300, -16'sd1000, 16'd2000, 1'b0);
      send_item(16'sd1000, -16'sd300, 16'd2000, 1'b0);
      // overmodulation drives duties out of range; the last command is near zero
      send_item(16'sd4000, 16'sd100, 16'd1000, 1'b0);
      send_item(-16'sd4000, -16'sd3000, 16'd1000, 1'b0);
      send_item(16'sd1, -16'sd1, 16'd65535, 1'b0);
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      directed_items();
      write_period(16'd65535);
      directed_items();
      write_period(16'd1);
      directed_items();
      write_period(16'd0);
      directed_items();
      write_period(16'd0);
      for (int ph = 0; ph < 6; ph++) begin
         write_period((ph == 0) ? 16'd65535 : (ph == 1) ? 16'd1 :
                      16'($urandom_range(1, 65535)));
         for (int n = 0; n < 90; n++) begin
            random_item(1'b1);
            if (n == 45 && ph == 2) drain_items();
         end
      end
      write_period(16'd2000);
      for (int n = 0; n < 100; n++) random_item(1'b0);
      drain_items();

      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
